/* rtl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Both macros expect clk_i and rst_ni in the scope of the module that uses them.

`define PDC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define PDC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/pdc_pkg.sv */
`timescale 1ns / 1ps

package pdc_pkg;

  localparam int unsigned INDEX_BITS_DEF = 20;
  localparam int unsigned ATOM_W         = 20;
  localparam int unsigned POS_W          = 32;
  localparam int unsigned AXES           = 3;
  localparam int unsigned ENTRY_W        = 21;
  localparam int unsigned ROW_W          = 63;
  localparam int unsigned RAD_W          = 32;
  localparam int unsigned CFG_IDX_W      = 3;

  localparam int unsigned D_W        = 33;
  localparam int unsigned PROD1_W    = 54;
  localparam int unsigned FSUM_W     = 56;
  localparam int unsigned FRAC_SHIFT = 35;
  localparam int unsigned FR_W       = 36;
  localparam int unsigned PROD2_W    = 57;
  localparam int unsigned CART_W     = 57;
  localparam int unsigned MAG_W      = 56;
  localparam int unsigned HALF_W     = 28;
  localparam int unsigned PP_W       = 56;
  localparam int unsigned SQ_W       = 112;
  localparam int unsigned SUM_W      = 113;
  localparam int unsigned RAD_SHIFT  = 74;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RECIP_0,
    REG_RECIP_1,
    REG_RECIP_2,
    REG_LATTICE_0,
    REG_LATTICE_1,
    REG_LATTICE_2,
    REG_RADIUS
  } cfg_reg_e;

  typedef logic [AXES-1:0][ROW_W-1:0] matrix_t;

  typedef struct packed {
    logic [ATOM_W-1:0] atom;
    logic              last;
  } tag_t;

  typedef struct packed {
    tag_t                         tag;
    logic [AXES-1:0][POS_W-1:0]   new_pos;
    logic [AXES-1:0][POS_W-1:0]   old_pos;
  } pos_item_t;

  typedef struct packed {
    tag_t                        tag;
    logic [AXES-1:0][FR_W-1:0]   fr;
  } frac_item_t;

  typedef struct packed {
    tag_t                        tag;
    logic [AXES-1:0][MAG_W-1:0]  mag;
  } mag_item_t;

  typedef struct packed {
    tag_t tag;
    logic displaced;
  } result_t;

  function automatic logic signed [ENTRY_W-1:0] row_entry(logic [ROW_W-1:0] row,
                                                         logic [1:0] k);
    return signed'(row[ENTRY_W*k +: ENTRY_W]);
  endfunction

endpackage

/* rtl/pdc_item_if.sv */
`timescale 1ns / 1ps

interface pdc_item_if #(
  parameter int unsigned INDEX_BITS = pdc_pkg::INDEX_BITS_DEF
) ();
  import pdc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [INDEX_BITS-1:0]   atom_index;
  logic signed [POS_W-1:0] new_x;
  logic signed [POS_W-1:0] new_y;
  logic signed [POS_W-1:0] new_z;
  logic signed [POS_W-1:0] old_x;
  logic signed [POS_W-1:0] old_y;
  logic signed [POS_W-1:0] old_z;
  logic                    last_atom;

  modport source (
    output valid, atom_index, new_x, new_y, new_z, old_x, old_y, old_z, last_atom,
    input  ready
  );

  modport sink (
    input  valid, atom_index, new_x, new_y, new_z, old_x, old_y, old_z, last_atom,
    output ready
  );
endinterface

/* rtl/pdc_result_if.sv */
`timescale 1ns / 1ps

interface pdc_result_if ();
  import pdc_pkg::*;

  logic              valid;
  logic              ready;
  logic [ATOM_W-1:0] atom_out;
  logic              displaced;
  logic              last_out;

  modport source (
    output valid, atom_out, displaced, last_out,
    input  ready
  );

  modport sink (
    input  valid, atom_out, displaced, last_out,
    output ready
  );
endinterface

/* rtl/pdc_frac.sv */
`timescale 1ns / 1ps

module pdc_frac (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  pdc_pkg::pos_item_t   in_item_i,
  input  pdc_pkg::matrix_t     recip_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output pdc_pkg::frac_item_t  out_item_o
);
  import pdc_pkg::*;

  localparam int unsigned      NST  = 4;
  localparam logic [FRAC_SHIFT-1:0] HALF = {1'b1, {(FRAC_SHIFT-1){1'b0}}};
  localparam logic [FR_W-1:0]  ONE  = {1'b1, {FRAC_SHIFT{1'b0}}};

  logic [NST-1:0] v_q;
  logic [NST-1:0] en;
  tag_t           tag_q [NST];

  logic signed [D_W-1:0]     d_q [AXES];
  logic signed [PROD1_W-1:0] p_q [AXES][AXES];
  logic signed [FSUM_W-1:0]  f_q [AXES];
  logic [AXES-1:0][FR_W-1:0] fr_q;

  // The remainder after taking off the nearest integer, ties to even.
  function automatic logic [FR_W-1:0] wrap_frac(logic signed [FSUM_W-1:0] f);
    logic [FRAC_SHIFT-1:0] rem;
    logic                  up;
    rem = f[FRAC_SHIFT-1:0];
    up  = (rem > HALF) || ((rem == HALF) && f[FRAC_SHIFT]);
    return up ? ({1'b0, rem} - ONE) : {1'b0, rem};
  endfunction

  assign en[NST-1] = !v_q[NST-1] || out_ready_i;
  for (genvar s = 0; s < NST - 1; s++) begin : g_en
    assign en[s] = !v_q[s] || en[s+1];
  end
  assign in_ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int s = 1; s < NST; s++) begin
        if (en[s]) v_q[s] <= v_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0] && in_valid_i) begin
      tag_q[0] <= in_item_i.tag;
      for (int k = 0; k < AXES; k++) begin
        d_q[k] <= D_W'(signed'(in_item_i.new_pos[k])) - D_W'(signed'(in_item_i.old_pos[k]));
      end
    end
    if (en[1] && v_q[0]) begin
      tag_q[1] <= tag_q[0];
      for (int i = 0; i < AXES; i++) begin
        for (int k = 0; k < AXES; k++) begin
          p_q[i][k] <= d_q[k] * row_entry(recip_i[i], 2'(k));
        end
      end
    end
    if (en[2] && v_q[1]) begin
      tag_q[2] <= tag_q[1];
      for (int i = 0; i < AXES; i++) begin
        f_q[i] <= FSUM_W'(p_q[i][0]) + FSUM_W'(p_q[i][1]) + FSUM_W'(p_q[i][2]);
      end
    end
    if (en[3] && v_q[2]) begin
      tag_q[3] <= tag_q[2];
      for (int i = 0; i < AXES; i++) begin
        fr_q[i] <= wrap_frac(f_q[i]);
      end
    end
  end

  assign out_valid_o    = v_q[NST-1];
  assign out_item_o.tag = tag_q[NST-1];
  assign out_item_o.fr  = fr_q;

endmodule

/* rtl/pdc_cart.sv */
`timescale 1ns / 1ps

module pdc_cart (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  pdc_pkg::frac_item_t  in_item_i,
  input  pdc_pkg::matrix_t     lattice_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output pdc_pkg::mag_item_t   out_item_o
);
  import pdc_pkg::*;

  localparam int unsigned NST = 3;

  logic [NST-1:0] v_q;
  logic [NST-1:0] en;
  tag_t           tag_q [NST];

  logic signed [PROD2_W-1:0]  q_q [AXES][AXES];
  logic signed [CART_W-1:0]   r_q [AXES];
  logic [AXES-1:0][MAG_W-1:0] mag_q;

  assign en[NST-1] = !v_q[NST-1] || out_ready_i;
  for (genvar s = 0; s < NST - 1; s++) begin : g_en
    assign en[s] = !v_q[s] || en[s+1];
  end
  assign in_ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int s = 1; s < NST; s++) begin
        if (en[s]) v_q[s] <= v_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0] && in_valid_i) begin
      tag_q[0] <= in_item_i.tag;
      for (int i = 0; i < AXES; i++) begin
        for (int k = 0; k < AXES; k++) begin
          q_q[i][k] <= signed'(in_item_i.fr[i]) * row_entry(lattice_i[i], 2'(k));
        end
      end
    end
    if (en[1] && v_q[0]) begin
      tag_q[1] <= tag_q[0];
      for (int k = 0; k < AXES; k++) begin
        r_q[k] <= CART_W'(q_q[0][k]) + CART_W'(q_q[1][k]) + CART_W'(q_q[2][k]);
      end
    end
    if (en[2] && v_q[1]) begin
      tag_q[2] <= tag_q[1];
      for (int k = 0; k < AXES; k++) begin
        mag_q[k] <= r_q[k][CART_W-1] ? MAG_W'(-r_q[k]) : MAG_W'(r_q[k]);
      end
    end
  end

  assign out_valid_o     = v_q[NST-1];
  assign out_item_o.tag  = tag_q[NST-1];
  assign out_item_o.mag  = mag_q;

endmodule

/* rtl/pdc_norm.sv */
`timescale 1ns / 1ps

module pdc_norm (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pdc_pkg::mag_item_t  in_item_i,
  input  logic [pdc_pkg::RAD_W-1:0] radius_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pdc_pkg::result_t    out_item_o
);
  import pdc_pkg::*;

  localparam int unsigned NST = 4;

  logic [NST-1:0] v_q;
  logic [NST-1:0] en;
  tag_t           tag_q [NST];

  logic [PP_W-1:0]  aa_q [AXES];
  logic [PP_W-1:0]  ab_q [AXES];
  logic [PP_W-1:0]  bb_q [AXES];
  logic [SQ_W-1:0]  sq_q [AXES];
  logic [SUM_W-1:0] tot_q;
  logic             disp_q;
  logic [SUM_W-1:0] thr;

  assign thr = SUM_W'({radius_i, {RAD_SHIFT{1'b0}}});

  assign en[NST-1] = !v_q[NST-1] || out_ready_i;
  for (genvar s = 0; s < NST - 1; s++) begin : g_en
    assign en[s] = !v_q[s] || en[s+1];
  end
  assign in_ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int s = 1; s < NST; s++) begin
        if (en[s]) v_q[s] <= v_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0] && in_valid_i) begin
      tag_q[0] <= in_item_i.tag;
      for (int k = 0; k < AXES; k++) begin
        aa_q[k] <= PP_W'(in_item_i.mag[k][MAG_W-1:HALF_W]) *
                   PP_W'(in_item_i.mag[k][MAG_W-1:HALF_W]);
        ab_q[k] <= PP_W'(in_item_i.mag[k][MAG_W-1:HALF_W]) *
                   PP_W'(in_item_i.mag[k][HALF_W-1:0]);
        bb_q[k] <= PP_W'(in_item_i.mag[k][HALF_W-1:0]) *
                   PP_W'(in_item_i.mag[k][HALF_W-1:0]);
      end
    end
    if (en[1] && v_q[0]) begin
      tag_q[1] <= tag_q[0];
      for (int k = 0; k < AXES; k++) begin
        sq_q[k] <= (SQ_W'(aa_q[k]) << (2 * HALF_W)) + (SQ_W'(ab_q[k]) << (HALF_W + 1)) +
                   SQ_W'(bb_q[k]);
      end
    end
    if (en[2] && v_q[1]) begin
      tag_q[2] <= tag_q[1];
      tot_q    <= SUM_W'(sq_q[0]) + SUM_W'(sq_q[1]) + SUM_W'(sq_q[2]);
    end
    if (en[3] && v_q[2]) begin
      tag_q[3] <= tag_q[2];
      disp_q   <= tot_q > thr;
    end
  end

  assign out_valid_o          = v_q[NST-1];
  assign out_item_o.tag       = tag_q[NST-1];
  assign out_item_o.displaced = disp_q;

endmodule

/* rtl/periodic_displacement_check_core.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Minimum-image displacement check for triclinic cells. One atom transaction is
// accepted per clock while no stall holds the pipeline; each verdict is formed by
// the eleven register stages of the arithmetic pipeline (displacement, reciprocal
// products, fraction sum, nearest-integer wrap, lattice products, Cartesian sum,
// magnitude, split square partial products, square assembly, length sum and the
// final compare, which is also the output register). A stall at the result side
// halts only the stages that are full, so bubbles are squeezed out and the input
// keeps accepting while any stage is free. The displaced flag is set when the
// squared distance is strictly greater than radius_squared. Matrices and radius reset
// to zero; the user must write them through the plain configuration port only while no
// transaction is in flight (the block does not enforce it); writes past the radius index are dropped.

module periodic_displacement_check_core #(
  parameter int unsigned INDEX_BITS = pdc_pkg::INDEX_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  pdc_item_if.sink                         items_i,
  pdc_result_if.source                     results_o,
  input  logic                             cfg_we_i,
  input  logic [pdc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [pdc_pkg::ROW_W-1:0]        cfg_data_i
);
  import pdc_pkg::*;

  localparam int unsigned KEEP_BITS = (INDEX_BITS < ATOM_W) ? INDEX_BITS : ATOM_W;

  matrix_t          recip_q;
  matrix_t          lattice_q;
  logic [RAD_W-1:0] radius_q;

  pos_item_t  pos_item;
  frac_item_t frac_item;
  mag_item_t  mag_item;
  result_t    res_item;
  logic       frac_valid;
  logic       frac_ready;
  logic       mag_valid;
  logic       mag_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recip_q   <= '0;
      lattice_q <= '0;
      radius_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_RECIP_0:   recip_q[0]   <= cfg_data_i;
        REG_RECIP_1:   recip_q[1]   <= cfg_data_i;
        REG_RECIP_2:   recip_q[2]   <= cfg_data_i;
        REG_LATTICE_0: lattice_q[0] <= cfg_data_i;
        REG_LATTICE_1: lattice_q[1] <= cfg_data_i;
        REG_LATTICE_2: lattice_q[2] <= cfg_data_i;
        REG_RADIUS:    radius_q     <= cfg_data_i[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  assign pos_item.tag.atom   = ATOM_W'(items_i.atom_index[KEEP_BITS-1:0]);
  assign pos_item.tag.last   = items_i.last_atom;
  assign pos_item.new_pos[0] = items_i.new_x;
  assign pos_item.new_pos[1] = items_i.new_y;
  assign pos_item.new_pos[2] = items_i.new_z;
  assign pos_item.old_pos[0] = items_i.old_x;
  assign pos_item.old_pos[1] = items_i.old_y;
  assign pos_item.old_pos[2] = items_i.old_z;

  pdc_frac u_frac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (items_i.valid),
    .in_ready_o  (items_i.ready),
    .in_item_i   (pos_item),
    .recip_i     (recip_q),
    .out_valid_o (frac_valid),
    .out_ready_i (frac_ready),
    .out_item_o  (frac_item)
  );

  pdc_cart u_cart (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (frac_valid),
    .in_ready_o  (frac_ready),
    .in_item_i   (frac_item),
    .lattice_i   (lattice_q),
    .out_valid_o (mag_valid),
    .out_ready_i (mag_ready),
    .out_item_o  (mag_item)
  );

  pdc_norm u_norm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (mag_valid),
    .in_ready_o  (mag_ready),
    .in_item_i   (mag_item),
    .radius_i    (radius_q),
    .out_valid_o (results_o.valid),
    .out_ready_i (results_o.ready),
    .out_item_o  (res_item)
  );

  assign results_o.atom_out  = res_item.tag.atom;
  assign results_o.displaced = res_item.displaced;
  assign results_o.last_out  = res_item.tag.last;

  `PDC_ASSERT_IMPL(a_input_free, results_o.ready, items_i.ready, "input stalled with a free output")
  `PDC_ASSERT_NEXT(a_frac_hold, frac_valid && !frac_ready, frac_valid && $stable(frac_item), "fraction transaction lost during a stall")
  `PDC_ASSERT_NEXT(a_mag_hold, mag_valid && !mag_ready, mag_valid && $stable(mag_item), "magnitude transaction lost during a stall")

endmodule
